// File: rtl/core/lav_pkg.sv
`timescale 1ns / 1ps

package lav_pkg;

  // signed q16.16 word and a normalized axis component (magnitude at most 1.0)
  typedef logic signed [31:0] q32_t;
  typedef logic signed [17:0] unit_t;

  // one queued transaction: eye, saturated eye-to-target difference, up hint
  typedef struct packed {
    q32_t [2:0] eye;
    q32_t [2:0] dir;
    q32_t [2:0] up;
  } item_t;

  // request to the normalizer
  typedef struct packed {
    logic        start;
    logic        negate;
    logic [30:0] fallback;
  } norm_req_t;

  // control that travels with one multiply-accumulate operation
  typedef struct packed {
    logic       valid;
    logic       dot;
    logic [1:0] tag;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_ISSUE,
    ST_WAIT,
    ST_NEXT,
    ST_OUT
  } back_st_t;

  // which axis the next normalize produces
  typedef enum logic [1:0] {
    STG_F,
    STG_S,
    STG_U,
    STG_T
  } stage_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_SQRT,
    N_LEN,
    N_DIV
  } norm_st_t;

  // register map, word index
  localparam logic [1:0] REG_FWD  = 2'd0;
  localparam logic [1:0] REG_SIDE = 2'd1;
  localparam logic [1:0] REG_UP   = 2'd2;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [30:0] ZERO_LEN_RESET = 31'd65536;
  localparam q32_t ONE_Q16 = 32'sd65536;

  // square root gives one result bit per step, division 17 quotient bits
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd16;

endpackage

// File: rtl/core/lav_front.sv
`timescale 1ns / 1ps

module lav_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lav_pkg::q32_t [2:0]      eye,
  input  lav_pkg::q32_t [2:0]      target,
  input  lav_pkg::q32_t [2:0]      up,
  output lav_pkg::item_t           q_item,
  output logic                     q_valid,
  input  logic                     q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lav_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           push;
  lav_pkg::item_t item_in;
  logic [32:0]    diff [3];

  assign in_ready = (count != CW'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rptr];

  // saturated eye-to-target difference
  always_comb begin
    item_in.eye = eye;
    item_in.up  = up;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {target[i][31], target[i]} - {eye[i][31], eye[i]};
      if (diff[i][32] != diff[i][31]) begin
        item_in.dir[i] = diff[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        item_in.dir[i] = diff[i][31:0];
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (q_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !q_pop) begin
        count <= count + CW'(1);
      end else if (!push && q_pop) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/lav_norm.sv
`timescale 1ns / 1ps

module lav_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  lav_pkg::norm_req_t    req,
  input  lav_pkg::q32_t [2:0]   vec,
  output logic                  busy,
  output logic                  done,
  output lav_pkg::unit_t [2:0]  res
);

  lav_pkg::norm_st_t state;
  lav_pkg::norm_st_t state_next;
  logic [31:0] mag [3];
  logic [2:0]  sgn;
  logic        negate;
  logic [30:0] fallback;
  logic [4:0]  cnt;
  logic [31:0] mag_sel;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] rem_sq;
  logic [63:0] root;
  logic [63:0] bitm;
  logic [63:0] trial;
  logic [31:0] len_den;
  logic        den_zero;
  logic [47:0] dsh;
  logic [47:0] rem_dv [3];
  logic [16:0] quo [3];
  logic [2:0]  qbit;
  logic        div_end;

  assign busy    = (state != lav_pkg::N_IDLE);
  assign trial   = root + bitm;
  assign div_end = (state == lav_pkg::N_DIV) && (cnt == lav_pkg::DIV_LAST);
  // a zero length only comes from an all-zero vector
  assign len_den = (root == 64'd0) ? {1'b0, fallback} : root[31:0];

  always_comb begin
    case (cnt[1:0])
      2'd0:    mag_sel = mag[0];
      2'd1:    mag_sel = mag[1];
      2'd2:    mag_sel = mag[2];
      default: mag_sel = 32'd0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qbit[i] = (rem_dv[i] >= dsh);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lav_pkg::N_IDLE: if (req.start) begin
        state_next = lav_pkg::N_SQ;
      end
      lav_pkg::N_SQ: if (cnt[1:0] == 2'd3) begin
        state_next = lav_pkg::N_SQRT;
      end
      lav_pkg::N_SQRT: if (cnt == lav_pkg::SQRT_LAST) begin
        state_next = lav_pkg::N_LEN;
      end
      lav_pkg::N_LEN: state_next = lav_pkg::N_DIV;
      lav_pkg::N_DIV: if (div_end) begin
        state_next = lav_pkg::N_IDLE;
      end
      default: state_next = lav_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lav_pkg::N_IDLE;
      done  <= 1'b0;
      cnt   <= 5'd0;
    end else begin
      state <= state_next;
      done  <= div_end;
      if (state == lav_pkg::N_IDLE || state_next != state) begin
        cnt <= 5'd0;
      end else begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  // sum of squares, square root, then one division lane per component
  always_ff @(posedge clk) begin
    case (state)
      lav_pkg::N_IDLE: if (req.start) begin
        for (int i = 0; i < 3; i++) begin
          sgn[i] <= vec[i][31];
          mag[i] <= vec[i][31] ? (~vec[i] + 32'd1) : vec[i];
        end
        negate   <= req.negate;
        fallback <= req.fallback;
        acc      <= 64'd0;
        prod     <= 64'd0;
      end
      lav_pkg::N_SQ: begin
        prod <= {32'd0, mag_sel} * {32'd0, mag_sel};
        acc  <= acc + prod;
        if (cnt[1:0] == 2'd3) begin
          rem_sq <= acc + prod;
          root   <= 64'd0;
          bitm   <= 64'h4000_0000_0000_0000;
        end
      end
      lav_pkg::N_SQRT: begin
        if (rem_sq >= trial) begin
          rem_sq <= rem_sq - trial;
          root   <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
      end
      lav_pkg::N_LEN: begin
        den_zero <= (len_den == 32'd0);
        dsh      <= {len_den, 16'd0};
        for (int i = 0; i < 3; i++) begin
          rem_dv[i] <= {mag[i], 16'd0} + {17'd0, len_den[31:1]};
          quo[i]    <= 17'd0;
        end
      end
      lav_pkg::N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (qbit[i]) begin
            rem_dv[i] <= rem_dv[i] - dsh;
          end
          quo[i] <= {quo[i][15:0], qbit[i]};
        end
        dsh <= dsh >> 1;
      end
      default: ;
    endcase
  end

  // signed result with the last quotient bit
  always_ff @(posedge clk) begin
    if (div_end) begin
      for (int i = 0; i < 3; i++) begin
        if (den_zero) begin
          res[i] <= 18'sd0;
        end else if (sgn[i] ^ negate) begin
          res[i] <= -{1'b0, quo[i][15:0], qbit[i]};
        end else begin
          res[i] <= {1'b0, quo[i][15:0], qbit[i]};
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("normalizer started while busy");

endmodule

// File: rtl/core/lav_mac.sv
`timescale 1ns / 1ps

module lav_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  lav_pkg::mac_ctl_t     ctl,
  input  lav_pkg::q32_t [2:0]   a,
  input  lav_pkg::unit_t [2:0]  b,
  output logic                  res_valid,
  output logic [1:0]            res_tag,
  output lav_pkg::q32_t         res
);

  lav_pkg::mac_ctl_t  ctl1;
  lav_pkg::mac_ctl_t  ctl2;
  logic signed [49:0] p [3];
  logic signed [51:0] sum;
  logic [51:0]        mag;
  logic [51:0]        rsum;
  logic [35:0]        rmag;
  logic               flip;
  lav_pkg::q32_t      res_n;

  // rounding to q16.16 with ties away from zero, optional negate, saturate
  always_comb begin
    mag  = sum[51] ? 52'(-sum) : 52'(sum);
    rsum = mag + 52'd32768;
    rmag = rsum[51:16];
    flip = sum[51] ^ ctl2.dot;
    if (!flip) begin
      res_n = (rmag > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rmag[31:0];
    end else begin
      res_n = (rmag > 36'h0_8000_0000) ? 32'h8000_0000 : (~rmag[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1      <= '0;
      ctl2      <= '0;
      res_valid <= 1'b0;
      res_tag   <= 2'd0;
    end else begin
      ctl1      <= ctl;
      ctl2      <= ctl1;
      res_valid <= ctl2.valid;
      res_tag   <= ctl2.tag;
    end
  end

  // products, then sum or difference, then round
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p[i] <= 50'($signed(a[i])) * 50'($signed(b[i]));
    end
    if (ctl1.dot) begin
      sum <= 52'(p[0]) + 52'(p[1]) + 52'(p[2]);
    end else begin
      sum <= 52'(p[0]) - 52'(p[1]);
    end
    res <= res_n;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> ##3 res_valid)
    else $error("mac result missing after three cycles");

endmodule

// File: rtl/core/lav_back.sv
`timescale 1ns / 1ps

module lav_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lav_pkg::item_t        q_item,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [30:0]           fwd_len,
  input  logic [30:0]           side_len,
  input  logic [30:0]           upaxis_len,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            row_index,
  output lav_pkg::q32_t         value_0,
  output lav_pkg::q32_t         value_1,
  output lav_pkg::q32_t         value_2,
  output lav_pkg::q32_t         value_3,
  output logic                  last_row
);

  lav_pkg::back_st_t    state;
  lav_pkg::back_st_t    state_next;
  lav_pkg::stage_t      stage;
  logic [1:0]           icnt;
  lav_pkg::q32_t [2:0]  eye;
  lav_pkg::q32_t [2:0]  up;
  lav_pkg::unit_t [2:0] f;
  lav_pkg::unit_t [2:0] s;
  lav_pkg::unit_t [2:0] u;
  lav_pkg::q32_t [2:0]  mres;

  lav_pkg::norm_req_t   nreq;
  lav_pkg::q32_t [2:0]  nvec;
  logic                 norm_busy;
  logic                 norm_done;
  lav_pkg::unit_t [2:0] norm_res;

  lav_pkg::mac_ctl_t    mctl;
  lav_pkg::q32_t [2:0]  ma;
  lav_pkg::unit_t [2:0] mb;
  lav_pkg::q32_t [2:0]  cross_a;
  lav_pkg::unit_t [2:0] cross_b;
  logic                 mac_valid;
  logic [1:0]           mac_tag;
  lav_pkg::q32_t        mac_res;

  lav_pkg::unit_t [2:0] ob_s;
  lav_pkg::unit_t [2:0] ob_u;
  lav_pkg::unit_t [2:0] ob_f;
  lav_pkg::q32_t [2:0]  ob_t;
  logic                 ob_full;
  logic [1:0]           row;

  lav_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .req  (nreq),
    .vec  (nvec),
    .busy (norm_busy),
    .done (norm_done),
    .res  (norm_res)
  );

  lav_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .a         (ma),
    .b         (mb),
    .res_valid (mac_valid),
    .res_tag   (mac_tag),
    .res       (mac_res)
  );

  // sequencer next state and requests
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    nreq       = '0;
    nvec       = q_item.dir;
    mctl       = '0;
    case (state)
      lav_pkg::ST_IDLE: if (q_valid) begin
        q_pop         = 1'b1;
        nreq.start    = 1'b1;
        nreq.negate   = 1'b1;
        nreq.fallback = fwd_len;
        state_next    = lav_pkg::ST_NORM;
      end
      lav_pkg::ST_NORM: if (norm_done) begin
        state_next = lav_pkg::ST_ISSUE;
      end
      lav_pkg::ST_ISSUE: begin
        mctl.valid = 1'b1;
        mctl.tag   = icnt;
        mctl.dot   = (stage == lav_pkg::STG_T);
        if (icnt == 2'd2) begin
          state_next = lav_pkg::ST_WAIT;
        end
      end
      lav_pkg::ST_WAIT: if (mac_valid && mac_tag == 2'd2) begin
        state_next = lav_pkg::ST_NEXT;
      end
      lav_pkg::ST_NEXT: begin
        if (stage == lav_pkg::STG_T) begin
          state_next = lav_pkg::ST_OUT;
        end else begin
          nreq.start    = 1'b1;
          nreq.negate   = 1'b0;
          nreq.fallback = (stage == lav_pkg::STG_S) ? side_len : upaxis_len;
          nvec          = mres;
          state_next    = lav_pkg::ST_NORM;
        end
      end
      lav_pkg::ST_OUT: if (!ob_full) begin
        state_next = lav_pkg::ST_IDLE;
      end
      default: state_next = lav_pkg::ST_IDLE;
    endcase
  end

  // cross product sources: up x f for the side axis, f x s for the up axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (stage == lav_pkg::STG_S) begin
        cross_a[i] = up[i];
        cross_b[i] = f[i];
      end else begin
        cross_a[i] = 32'($signed(f[i]));
        cross_b[i] = s[i];
      end
    end
  end

  // operands of the multiply-accumulate for each issued operation
  always_comb begin
    ma = '0;
    mb = '0;
    if (stage == lav_pkg::STG_T) begin
      ma = eye;
      case (icnt)
        2'd0:    mb = s;
        2'd1:    mb = u;
        default: mb = f;
      endcase
    end else begin
      case (icnt)
        2'd0: begin
          ma[0] = cross_a[1]; ma[1] = cross_a[2];
          mb[0] = cross_b[2]; mb[1] = cross_b[1];
        end
        2'd1: begin
          ma[0] = cross_a[2]; ma[1] = cross_a[0];
          mb[0] = cross_b[0]; mb[1] = cross_b[2];
        end
        default: begin
          ma[0] = cross_a[0]; ma[1] = cross_a[1];
          mb[0] = cross_b[1]; mb[1] = cross_b[0];
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lav_pkg::ST_IDLE;
      stage   <= lav_pkg::STG_F;
      icnt    <= 2'd0;
      ob_full <= 1'b0;
      row     <= 2'd0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        stage <= lav_pkg::STG_F;
      end
      if (state == lav_pkg::ST_NORM && norm_done) begin
        icnt <= 2'd0;
        case (stage)
          lav_pkg::STG_F: stage <= lav_pkg::STG_S;
          lav_pkg::STG_S: stage <= lav_pkg::STG_U;
          default:        stage <= lav_pkg::STG_T;
        endcase
      end
      if (state == lav_pkg::ST_ISSUE) begin
        icnt <= icnt + 2'd1;
      end
      if (out_valid && out_ready) begin
        row <= row + 2'd1;
        if (row == 2'd3) begin
          ob_full <= 1'b0;
        end
      end
      if (state == lav_pkg::ST_OUT && !ob_full) begin
        ob_full <= 1'b1;
        row     <= 2'd0;
      end
    end
  end

  // working vectors and the output buffer
  always_ff @(posedge clk) begin
    if (q_pop) begin
      eye <= q_item.eye;
      up  <= q_item.up;
    end
    if (state == lav_pkg::ST_NORM && norm_done) begin
      case (stage)
        lav_pkg::STG_F: f <= norm_res;
        lav_pkg::STG_S: s <= norm_res;
        default:        u <= norm_res;
      endcase
    end
    if (state == lav_pkg::ST_WAIT && mac_valid) begin
      mres[mac_tag] <= mac_res;
    end
    if (state == lav_pkg::ST_OUT && !ob_full) begin
      ob_s <= s;
      ob_u <= u;
      ob_f <= f;
      ob_t <= mres;
    end
  end

  // row select from the output buffer
  always_comb begin
    out_valid = ob_full;
    row_index = row;
    last_row  = (row == 2'd3);
    case (row)
      2'd3: begin
        value_0 = ob_t[0];
        value_1 = ob_t[1];
        value_2 = ob_t[2];
        value_3 = lav_pkg::ONE_Q16;
      end
      default: begin
        value_0 = 32'($signed(ob_s[row]));
        value_1 = 32'($signed(ob_u[row]));
        value_2 = 32'($signed(ob_f[row]));
        value_3 = 32'sd0;
      end
    endcase
  end

  a_last_row_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_row) |=> !out_valid)
    else $error("output buffer not released after last row");

  a_wait_result: assert property (@(posedge clk) disable iff (rst)
    (state == lav_pkg::ST_NEXT) |-> $past(mac_valid && mac_tag == 2'd2))
    else $error("sequencer advanced without final mac result");

endmodule

// File: rtl/core/look_at_view_matrix.sv
`timescale 1ns / 1ps

// Look-at view matrix builder. Each input transaction (eye, target, up hint,
// all signed Q16.16) produces four output transactions, the matrix rows 0..3
// with row_index and last_row marking them; rows 0..2 carry the side, up and
// forward axis components and row 3 the negated eye dot products and 1.0.
// The single shared normalizer runs three times per item, each run being a
// sum of squares, a 32-step square root and a 17-step division, each
// followed by a multiply-accumulate burst for the cross and dot products;
// besides these the back end takes the item from the queue and loads the
// output buffer. A queue of QUEUE_DEPTH items in front and a four-row
// output buffer behind let inputs and result reads proceed while the next
// matrix is computed.
// Registers at byte offsets 0, 4 and 8 hold the zero-length fallbacks for
// the forward, side and up axes (31 bits, reset 1.0).
module look_at_view_matrix #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lav_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   eye_x,
  input  logic signed [31:0]                   eye_y,
  input  logic signed [31:0]                   eye_z,
  input  logic signed [31:0]                   target_x,
  input  logic signed [31:0]                   target_y,
  input  logic signed [31:0]                   target_z,
  input  logic signed [31:0]                   up_x,
  input  logic signed [31:0]                   up_y,
  input  logic signed [31:0]                   up_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           row_index,
  output logic signed [31:0]                   value_0,
  output logic signed [31:0]                   value_1,
  output logic signed [31:0]                   value_2,
  output logic signed [31:0]                   value_3,
  output logic                                 last_row
);

  logic [30:0]         forward_zero_len;
  logic [30:0]         side_zero_len;
  logic [30:0]         upaxis_zero_len;
  logic                cfg_wr;
  lav_pkg::item_t      q_item;
  logic                q_valid;
  logic                q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_zero_len <= lav_pkg::ZERO_LEN_RESET;
      side_zero_len    <= lav_pkg::ZERO_LEN_RESET;
      upaxis_zero_len  <= lav_pkg::ZERO_LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lav_pkg::REG_FWD:  forward_zero_len <= pwdata[30:0];
        lav_pkg::REG_SIDE: side_zero_len    <= pwdata[30:0];
        lav_pkg::REG_UP:   upaxis_zero_len  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      lav_pkg::REG_FWD:  prdata = {1'b0, forward_zero_len};
      lav_pkg::REG_SIDE: prdata = {1'b0, side_zero_len};
      lav_pkg::REG_UP:   prdata = {1'b0, upaxis_zero_len};
      default:           prdata = 32'd0;
    endcase
  end

  lav_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .eye      ({eye_z, eye_y, eye_x}),
    .target   ({target_z, target_y, target_x}),
    .up       ({up_z, up_y, up_x}),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  lav_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .fwd_len    (forward_zero_len),
    .side_len   (side_zero_len),
    .upaxis_len (upaxis_zero_len),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .value_0    (value_0),
    .value_1    (value_1),
    .value_2    (value_2),
    .value_3    (value_3),
    .last_row   (last_row)
  );

endmodule

// File: tb/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

  localparam int LIMIT = 800000;
  localparam int DRAIN = 400;

  // one matrix row as it leaves the block
  typedef struct packed {
    logic [1:0] idx;
    lav_pkg::q32_t [3:0] val;
    logic       last;
  } mat_row_t;

  // expected rows and a fixed-point copy of the look-at math
  class view_matrix_board;
    mat_row_t rows_due[$];
    longint unsigned fwd_len, side_len, up_len;
    int errors;

    function new();
      fwd_len = 65536;
      side_len = 65536;
      up_len = 65536;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_len(logic [1:0] which, logic [31:0] data);
      case (which)
        lav_pkg::REG_FWD:  fwd_len = data[30:0];
        lav_pkg::REG_SIDE: side_len = data[30:0];
        lav_pkg::REG_UP:   up_len = data[30:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // q32.32 to q16.16, ties away from zero
    function longint rnd_q(longint x);
      longint unsigned m;
      longint unsigned r;
      m = x < 0 ? -x : x;
      r = (m + 32768) >> 16;
      return x < 0 ? -longint'(r) : longint'(r);
    endfunction

    function longint div_rnd(longint num, longint unsigned den);
      longint unsigned m;
      longint unsigned q;
      if (den == 0) return 0;
      m = num < 0 ? -num : num;
      q = (m + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void unitize(inout longint v[3], input longint unsigned fb, input bit neg);
      longint unsigned acc;
      longint unsigned m;
      longint q;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m = v[i] < 0 ? -v[i] : v[i];
        acc += m * m;
      end
      acc = root(acc);
      if (acc == 0) acc = fb;
      for (int i = 0; i < 3; i++) begin
        q = div_rnd(v[i] * 65536, acc);
        v[i] = neg ? -q : q;
      end
    endfunction

    function void cross3(input longint a[3], input longint b[3], output longint r[3]);
      r[0] = sat(rnd_q(a[1] * b[2] - a[2] * b[1]));
      r[1] = sat(rnd_q(a[2] * b[0] - a[0] * b[2]));
      r[2] = sat(rnd_q(a[0] * b[1] - a[1] * b[0]));
    endfunction

    function longint eye_term(longint e[3], longint a[3]);
      return sat(-rnd_q(e[0] * a[0] + e[1] * a[1] + e[2] * a[2]));
    endfunction

    // accepted input: push the four rows of its matrix
    function void note_scene(lav_pkg::q32_t pt[9]);
      longint eye[3], up[3], f[3], s[3], u[3];
      mat_row_t r;
      for (int i = 0; i < 3; i++) begin
        eye[i] = longint'(pt[i]);
        f[i] = sat(longint'(pt[3 + i]) - eye[i]);
        up[i] = longint'(pt[6 + i]);
      end
      unitize(f, fwd_len, 1'b1);
      cross3(up, f, s);
      unitize(s, side_len, 1'b0);
      cross3(f, s, u);
      unitize(u, up_len, 1'b0);
      for (int k = 0; k < 3; k++) begin
        r.idx = 2'(k);
        r.val[0] = 32'(s[k]);
        r.val[1] = 32'(u[k]);
        r.val[2] = 32'(f[k]);
        r.val[3] = '0;
        r.last = 1'b0;
        rows_due.push_back(r);
      end
      r.idx = 2'd3;
      r.val[0] = 32'(eye_term(eye, s));
      r.val[1] = 32'(eye_term(eye, u));
      r.val[2] = 32'(eye_term(eye, f));
      r.val[3] = lav_pkg::ONE_Q16;
      r.last = 1'b1;
      rows_due.push_back(r);
    endfunction

    task check_row(mat_row_t got);
      mat_row_t exp_r;
      if (rows_due.size() == 0) begin
        report($sformatf("unexpected row %0d", got.idx));
      end else begin
        exp_r = rows_due.pop_front();
        if (got.idx !== exp_r.idx)
          report($sformatf("row_index %0d, want %0d", got.idx, exp_r.idx));
        for (int i = 0; i < 4; i++)
          if (got.val[i] !== exp_r.val[i])
            report($sformatf("row %0d value_%0d %h, want %h", exp_r.idx, i,
                             got.val[i], exp_r.val[i]));
        if (got.last !== exp_r.last)
          report($sformatf("row %0d last_row %b, want %b", exp_r.idx, got.last,
                           exp_r.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [lav_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  lav_pkg::q32_t eye_x = 0, eye_y = 0, eye_z = 0;
  lav_pkg::q32_t target_x = 0, target_y = 0, target_z = 0;
  lav_pkg::q32_t up_x = 0, up_y = 0, up_z = 0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row_index;
  lav_pkg::q32_t value_0, value_1, value_2, value_3;
  logic last_row;

  view_matrix_board board = new();
  int cycles = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  look_at_view_matrix uut (.*);

  always #4 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[look_at_view_matrix] ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_row({row_index, value_3, value_2, value_1, value_0, last_row});
  end

  // result side stalls
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 30) == 0) calm_out = ~calm_out;
      n = calm_out ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task cfg_write(logic [1:0] which, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {which, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_len(which, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task set_all(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    cfg_write(lav_pkg::REG_FWD, a);
    cfg_write(lav_pkg::REG_SIDE, b);
    cfg_write(lav_pkg::REG_UP, c);
  endtask

  // called at a falling edge; leaves at a falling edge
  task send_scene(lav_pkg::q32_t pt[9]);
    int n;
    if ($urandom_range(0, 40) == 0) calm_in = ~calm_in;
    n = calm_in ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    {eye_x, eye_y, eye_z} = {pt[0], pt[1], pt[2]};
    {target_x, target_y, target_z} = {pt[3], pt[4], pt[5]};
    {up_x, up_y, up_z} = {pt[6], pt[7], pt[8]};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_scene(pt);
    @(negedge clk);
  endtask

  // called at a falling edge right after the last accepted transaction
  task settle();
    in_valid = 1'b0;
    while (board.rows_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function lav_pkg::q32_t coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  task random_scenes(int count);
    lav_pkg::q32_t pt[9];
    int kind;
    int shape;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < 9; i++) pt[i] = coord(kind);
      shape = $urandom_range(0, 19);
      // degenerate scenes: eye on target, up along the view direction, or zero up
      if (shape == 0) begin
        pt[3] = pt[0]; pt[4] = pt[1]; pt[5] = pt[2];
      end else if (shape == 1) begin
        pt[6] = pt[3] - pt[0]; pt[7] = pt[4] - pt[1]; pt[8] = pt[5] - pt[2];
      end else if (shape == 2) begin
        pt[6] = 0; pt[7] = 0; pt[8] = 0;
      end
      send_scene(pt);
    end
  endtask

  task directed_scenes();
    lav_pkg::q32_t mx, mn;
    lav_pkg::q32_t pt[9];
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    // plain camera
    pt = '{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0};
    send_scene(pt);
    // eye on target
    pt = '{3 << 16, 2 << 16, 1 << 16, 3 << 16, 2 << 16, 1 << 16, 0, 1 << 16, 0};
    send_scene(pt);
    // up parallel to view direction
    pt = '{0, 0, 0, 0, 4 << 16, 0, 0, 1 << 16, 0};
    send_scene(pt);
    // zero up hint
    pt = '{1, 2, 3, 7 << 16, -5 << 16, 9 << 16, 0, 0, 0};
    send_scene(pt);
    // everything zero
    pt = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_scene(pt);
    // difference saturates both ways
    pt = '{mn, mx, mn, mx, mn, mx, mx, mn, mx};
    send_scene(pt);
    pt = '{mx, mn, mx, mn, mx, mn, mn, mx, mn};
    send_scene(pt);
    // all extremes
    pt = '{mx, mx, mx, 0, 0, 0, mx, mx, mx};
    send_scene(pt);
    pt = '{mn, mn, mn, 0, 0, 0, mn, mn, mn};
    send_scene(pt);
    pt = '{-1, -1, -1, 1, 1, 1, -1, 0, 1};
    send_scene(pt);
    pt = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
    send_scene(pt);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_scenes();
    random_scenes(80);
    settle();
    set_all(32'd1, 32'h7FFF_FFFF, 32'd0);
    directed_scenes();
    random_scenes(90);
    settle();
    set_all(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF);
    directed_scenes();
    random_scenes(80);
    settle();
    set_all($urandom, $urandom, $urandom);
    random_scenes(80);
    settle();
    set_all(32'd65536, 32'd65536, 32'd65536);
    random_scenes(60);
    in_valid = 1'b0;
    while (board.rows_due.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (board.rows_due.size() != 0)
      board.report($sformatf("%0d rows never arrived", board.rows_due.size()));
    if (board.errors == 0) begin
      $display("[look_at_view_matrix] OK");
    end else begin
      $display("[look_at_view_matrix] ERROR");
    end
    $finish;
  end

endmodule
